### rtl/core/st_pkg.sv
`timescale 1ns / 1ps
// st_pkg: shared types, token kind codes and keyword tables for the source tokenizer.
// No dependencies; used by st_lexer, st_out_fifo, source_tokenizer_top and the bench.
package st_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_STR,
		MODE_COMMENT,
		MODE_EQ,
		MODE_BANG,
		MODE_SLASH
	} mode_t;

	localparam int KW_COUNT = 12;
	localparam logic [KW_COUNT-1:0] KW_ALL = '1;

	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_IDENT   = 6'd1;
	localparam logic [5:0] K_INT     = 6'd2;
	localparam logic [5:0] K_STR     = 6'd3;
	localparam logic [5:0] K_KW0     = 6'd4;
	localparam logic [5:0] K_PLUS    = 6'd16;
	localparam logic [5:0] K_MINUS   = 6'd17;
	localparam logic [5:0] K_STAR    = 6'd18;
	localparam logic [5:0] K_SLASH   = 6'd19;
	localparam logic [5:0] K_PCT     = 6'd20;
	localparam logic [5:0] K_LPAREN  = 6'd21;
	localparam logic [5:0] K_RPAREN  = 6'd22;
	localparam logic [5:0] K_LBRACE  = 6'd23;
	localparam logic [5:0] K_RBRACE  = 6'd24;
	localparam logic [5:0] K_SEMI    = 6'd25;
	localparam logic [5:0] K_COMMA   = 6'd26;
	localparam logic [5:0] K_DOT     = 6'd27;
	localparam logic [5:0] K_LT      = 6'd28;
	localparam logic [5:0] K_GT      = 6'd29;
	localparam logic [5:0] K_EQUAL   = 6'd30;
	localparam logic [5:0] K_EQEQ    = 6'd31;
	localparam logic [5:0] K_NEQ     = 6'd32;
	localparam logic [5:0] K_UNKNOWN = 6'd33;

	// keyword text, right-justified: first char is the most significant used byte
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		"var", "function", "if", "else", "while", "return",
		"true", "false", "class", "extends", "virtual", "new"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd8, 4'd2, 4'd4, 4'd5, 4'd6, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd3
	};

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        unknown_char;
		logic        last_result;
	} token_t;

	// up to two tokens produced by one source beat, already in order
	typedef struct packed {
		logic [1:0] cnt;
		token_t     first;
		token_t     second;
	} tok_pair_t;

	function automatic token_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic unk);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = start;
		t.token_length = len;
		t.unknown_char = unk;
		t.last_result  = 1'b0;
		return t;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// only meaningful for i below the keyword length
	function automatic logic [7:0] kw_byte(input int k, input logic [2:0] i);
		logic [63:0] w;
		logic [3:0]  sh;
		w  = KW_TEXT[k];
		sh = KW_LEN[k] - 4'd1 - {1'b0, i};
		return w[{sh[2:0], 3'b000} +: 8];
	endfunction

	// idx is clamped by the caller: 8 or more matches nothing
	function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] mask,
			input logic [7:0] c, input logic [3:0] idx);
		logic [KW_COUNT-1:0] keep;
		keep = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			keep[k] = mask[k] && (idx < KW_LEN[k]) && (kw_byte(k, idx[2:0]) == c);
		end
		return keep;
	endfunction

	// last surviving candidate of matching length wins
	function automatic logic [5:0] kw_kind(input logic [KW_COUNT-1:0] mask,
			input logic [3:0] len);
		logic [5:0] kind;
		kind = K_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (mask[k] && KW_LEN[k] == len) begin
				kind = K_KW0 + 6'(k);
			end
		end
		return kind;
	endfunction

endpackage

### rtl/core/st_in_if.sv
`timescale 1ns / 1ps
// st_in_if: valid/ready channel carrying one source byte or the end marker.
// No dependencies.
interface st_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

### rtl/core/st_out_if.sv
`timescale 1ns / 1ps
// st_out_if: valid/ready channel carrying one token.
// No dependencies.
interface st_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        unknown_char;
	logic        last_result;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output unknown_char, output last_result, input ready);
	modport sink   (input valid, input token_kind, input token_start, input token_length,
		input unknown_char, input last_result, output ready);
endinterface

### rtl/core/st_lexer.sv
`timescale 1ns / 1ps
// st_lexer: scan state registers and next-state / token logic for one source beat.
// Depends on st_pkg.
module st_lexer
	import st_pkg::*;
#(
	parameter int POS_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] c,
	input  logic       eoi,
	output tok_pair_t  pair
);

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] pstart_q, pstart_d;
	logic [POS_BITS-1:0] plen_q, plen_d;
	logic [KW_COUNT-1:0] kw_q, kw_d;

	logic [POS_BITS-1:0] pos_inc;
	logic [15:0]         pos16;
	logic [3:0]          idx4;
	logic [3:0]          len4;

	logic                fl_v;
	token_t              fl_tok;
	logic                st_v;
	token_t              st_tok;
	mode_t               st_mode;
	logic [POS_BITS-1:0] st_start;
	logic [POS_BITS-1:0] st_len;
	logic [KW_COUNT-1:0] st_kw;
	logic [5:0]          p_kind;

	logic                a_v, b_v, take_start;
	token_t              a_tok, b_tok;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + POS_BITS'(1);
	endfunction

	assign pos_inc = sat_inc(pos_q);
	assign pos16   = 16'(pos_q);
	assign idx4    = (plen_q > POS_BITS'(8)) ? 4'd8 : plen_q[3:0];
	assign len4    = (plen_q > POS_BITS'(15)) ? 4'd15 : plen_q[3:0];

	// token for whatever is pending
	always_comb begin
		fl_v   = 1'b1;
		fl_tok = '0;
		unique case (mode_q)
			MODE_IDENT: fl_tok = mk_tok(kw_kind(kw_q, len4), 16'(pstart_q), 16'(plen_q), 1'b0);
			MODE_INT:   fl_tok = mk_tok(K_INT, 16'(pstart_q), 16'(plen_q), 1'b0);
			MODE_STR:   fl_tok = mk_tok(K_STR, 16'(pstart_q), 16'(plen_q), 1'b0);
			MODE_EQ:    fl_tok = mk_tok(K_EQUAL, 16'(pstart_q), 16'd1, 1'b0);
			MODE_BANG:  fl_tok = mk_tok(K_UNKNOWN, 16'(pstart_q), 16'd1, 1'b1);
			MODE_SLASH: fl_tok = mk_tok(K_SLASH, 16'(pstart_q), 16'd1, 1'b0);
			default:    fl_v = 1'b0;
		endcase
	end

	// what the byte does when it opens a new token
	always_comb begin
		st_mode  = MODE_IDLE;
		st_start = '0;
		st_len   = '0;
		st_kw    = KW_ALL;
		st_v     = 1'b0;
		p_kind   = K_UNKNOWN;
		if (is_space(c)) begin
			st_v = 1'b0;
		end else if (is_alpha(c) || c == "_") begin
			st_mode  = MODE_IDENT;
			st_start = pos_q;
			st_len   = POS_BITS'(1);
			st_kw    = kw_filter(KW_ALL, c, 4'd0);
		end else if (is_digit(c)) begin
			st_mode  = MODE_INT;
			st_start = pos_q;
			st_len   = POS_BITS'(1);
		end else begin
			case (c)
				"\"": begin st_mode = MODE_STR; st_start = pos_inc; end
				"=": begin st_mode = MODE_EQ; st_start = pos_q; end
				"!": begin st_mode = MODE_BANG; st_start = pos_q; end
				"/": begin st_mode = MODE_SLASH; st_start = pos_q; end
				"+": p_kind = K_PLUS;
				"-": p_kind = K_MINUS;
				"*": p_kind = K_STAR;
				"%": p_kind = K_PCT;
				"(": p_kind = K_LPAREN;
				")": p_kind = K_RPAREN;
				"{": p_kind = K_LBRACE;
				"}": p_kind = K_RBRACE;
				";": p_kind = K_SEMI;
				",": p_kind = K_COMMA;
				".": p_kind = K_DOT;
				"<": p_kind = K_LT;
				">": p_kind = K_GT;
				default: p_kind = K_UNKNOWN;
			endcase
			st_v = (st_mode == MODE_IDLE);
		end
		st_tok = mk_tok(p_kind, pos16, 16'd1, p_kind == K_UNKNOWN);
	end

	always_comb begin
		mode_d     = mode_q;
		pos_d      = pos_q;
		pstart_d   = pstart_q;
		plen_d     = plen_q;
		kw_d       = kw_q;
		a_v        = 1'b0;
		a_tok      = fl_tok;
		b_v        = 1'b0;
		b_tok      = st_tok;
		take_start = 1'b0;
		if (eoi) begin
			a_v      = fl_v;
			b_v      = 1'b1;
			b_tok    = mk_tok(K_EOF, pos16, 16'd0, 1'b0);
			mode_d   = MODE_IDLE;
			pos_d    = '0;
			pstart_d = '0;
			plen_d   = '0;
			kw_d     = KW_ALL;
		end else begin
			pos_d = pos_inc;
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						kw_d   = kw_filter(kw_q, c, idx4);
						plen_d = sat_inc(plen_q);
					end else begin
						take_start = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_digit(c)) plen_d = sat_inc(plen_q);
					else take_start = 1'b1;
				end
				MODE_STR: begin
					if (c == "\"") begin
						a_v      = 1'b1;
						mode_d   = MODE_IDLE;
						pstart_d = '0;
						plen_d   = '0;
						kw_d     = KW_ALL;
					end else begin
						plen_d = sat_inc(plen_q);
					end
				end
				MODE_COMMENT: begin
					if (c == "\n") mode_d = MODE_IDLE;
				end
				MODE_EQ, MODE_BANG: begin
					if (c == "=") begin
						a_v      = 1'b1;
						a_tok    = mk_tok((mode_q == MODE_EQ) ? K_EQEQ : K_NEQ,
							16'(pstart_q), 16'd2, 1'b0);
						mode_d   = MODE_IDLE;
						pstart_d = '0;
						plen_d   = '0;
						kw_d     = KW_ALL;
					end else begin
						take_start = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (c == "/") begin
						mode_d   = MODE_COMMENT;
						pstart_d = '0;
						plen_d   = '0;
						kw_d     = KW_ALL;
					end else begin
						take_start = 1'b1;
					end
				end
				MODE_IDLE: take_start = 1'b1;
			endcase
			// lookahead: the byte may close the pending token and open another
			if (take_start) begin
				a_v      = fl_v;
				b_v      = st_v;
				mode_d   = st_mode;
				pstart_d = st_start;
				plen_d   = st_len;
				kw_d     = st_kw;
			end
		end
	end

	// compact into order and flag the final token of the beat
	always_comb begin
		pair.cnt    = {1'b0, a_v} + {1'b0, b_v};
		pair.first  = a_v ? a_tok : b_tok;
		pair.second = b_tok;
		pair.first.last_result  = !(a_v && b_v);
		pair.second.last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			kw_q     <= KW_ALL;
		end else if (step) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			kw_q     <= kw_d;
		end
	end

endmodule

### rtl/core/st_out_fifo.sv
`timescale 1ns / 1ps
// st_out_fifo: four-entry token queue, takes up to two tokens per cycle, gives one.
// Depends on st_pkg.
module st_out_fifo
	import st_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t push,
	input  logic      pop,
	output token_t    head,
	output logic      not_empty,
	output logic      room2
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	token_t         mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= (AW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.first;
		if (push.cnt == 2'd2) mem_q[wr_q + AW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.cnt);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push.cnt) - (AW+1)'(pop);
		end
	end

endmodule

### rtl/core/source_tokenizer_top.sv
`timescale 1ns / 1ps
// source_tokenizer_top: streaming lexer, byte beats in, token beats out.
// Depends on st_pkg, st_in_if, st_out_if, st_lexer, st_out_fifo.
//
//  channel  dir  payload                                              beat
//  chars    in   char_byte[7:0], end_of_input                         valid & ready
//  tokens   out  token_kind[5:0], token_start[15:0], token_length[15:0],
//                unknown_char, last_result                            valid & ready
//
// One source beat per cycle is taken while the queue has room. A beat is registered in the input stage,
// where the lexer decodes it against the scan state; its tokens (none, one or two)
// land in a four-entry queue, which presents them on tokens one at a time, in order.
// A beat that yields two tokens leaves the queue as two token beats.
// The input stage holds while the queue has fewer than two free slots.
// Reset empties the queue and puts the scanner idle at offset zero.
module source_tokenizer_top
	import st_pkg::*;
#(
	parameter int POS_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	st_in_if.sink    chars,
	st_out_if.source tokens
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       fire_s1;
	logic       room2;
	logic       not_empty;
	tok_pair_t  pair;
	tok_pair_t  push;
	token_t     head;

	assign fire_s1     = valid_s1 && room2;
	assign chars.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_byte;
			eoi_s1  <= chars.end_of_input;
		end
	end

	st_lexer #(.POS_BITS(POS_BITS)) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire_s1),
		.c      (char_s1),
		.eoi    (eoi_s1),
		.pair   (pair)
	);

	always_comb begin
		push     = pair;
		push.cnt = fire_s1 ? pair.cnt : 2'd0;
	end

	st_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (tokens.valid && tokens.ready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	assign tokens.valid        = not_empty;
	assign tokens.token_kind   = head.token_kind;
	assign tokens.token_start  = head.token_start;
	assign tokens.token_length = head.token_length;
	assign tokens.unknown_char = head.unknown_char;
	assign tokens.last_result  = head.last_result;

endmodule

### bench/source_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// source_tokenizer_top_tb: self-checking bench for the streaming source tokenizer.
// Depends on st_pkg, st_in_if, st_out_if and source_tokenizer_top; a lexer model
// inside predicts every token beat and a monitor compares the stream in order.
module source_tokenizer_top_tb;
	import st_pkg::*;

	localparam int POS_BITS = 16;
	localparam int unsigned POS_TOP = (1 << POS_BITS) - 1;
	localparam int RANDOM_BEATS = 750;
	localparam int HOLD_CYCLES = 300;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       burst;
	} src_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	st_in_if  chars ();
	st_out_if tokens ();

	source_tokenizer_top #(.POS_BITS(POS_BITS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	string kw_words [KW_COUNT] = '{
		"var", "function", "if", "else", "while", "return",
		"true", "false", "class", "extends", "virtual", "new"
	};
	string punct_chars = "+-*/%(){};,.<>=";

	src_beat_t byte_queue [$];
	token_t    due_tokens [$];
	token_t    fresh [$];
	int        mismatches = 0;

	// lexer state mirrored by the predictor
	mode_t               scan;
	int unsigned         at_pos;
	int unsigned         tok_start;
	int unsigned         tok_len;
	logic [KW_COUNT-1:0] kw_live;

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	function automatic int unsigned bump(input int unsigned v);
		return (v >= POS_TOP) ? POS_TOP : v + 1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [KW_COUNT-1:0] narrow_kw(input logic [KW_COUNT-1:0] live,
			input logic [7:0] c, input int unsigned idx);
		logic [KW_COUNT-1:0] keep;
		keep = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (live[k] && idx < kw_words[k].len() && kw_words[k][idx] == c) begin
				keep[k] = 1'b1;
			end
		end
		return keep;
	endfunction

	function automatic void add_token(input logic [5:0] kind, input int unsigned start,
			input int unsigned len, input logic unk);
		token_t t;
		t.token_kind   = kind;
		t.token_start  = start[15:0];
		t.token_length = len[15:0];
		t.unknown_char = unk;
		t.last_result  = 1'b0;
		fresh.push_back(t);
	endfunction

	function automatic void clear_scan();
		scan      = MODE_IDLE;
		tok_start = 0;
		tok_len   = 0;
		kw_live   = '1;
	endfunction

	function automatic void close_token();
		logic [5:0] kind;
		kind = K_IDENT;
		case (scan)
			MODE_IDENT: begin
				// last surviving keyword of the right length wins
				for (int k = 0; k < KW_COUNT; k++) begin
					if (kw_live[k] && kw_words[k].len() == tok_len) begin
						kind = K_KW0 + 6'(k);
					end
				end
				add_token(kind, tok_start, tok_len, 1'b0);
			end
			MODE_INT:   add_token(K_INT, tok_start, tok_len, 1'b0);
			MODE_STR:   add_token(K_STR, tok_start, tok_len, 1'b0);
			MODE_EQ:    add_token(K_EQUAL, tok_start, 1, 1'b0);
			MODE_BANG:  add_token(K_UNKNOWN, tok_start, 1, 1'b1);
			MODE_SLASH: add_token(K_SLASH, tok_start, 1, 1'b0);
			default: ;
		endcase
		clear_scan();
	endfunction

	function automatic void open_token(input logic [7:0] c, input int unsigned p);
		logic [5:0] kind;
		clear_scan();
		kind = K_UNKNOWN;
		if (is_blank(c)) begin
			return;
		end
		if (is_letter(c) || c == CH_USCORE) begin
			scan      = MODE_IDENT;
			tok_start = p;
			tok_len   = 1;
			kw_live   = narrow_kw('1, c, 0);
			return;
		end
		if (is_numeral(c)) begin
			scan      = MODE_INT;
			tok_start = p;
			tok_len   = 1;
			return;
		end
		case (c)
			CH_QUOTE: begin
				scan      = MODE_STR;
				tok_start = bump(p);
				return;
			end
			CH_EQ: begin
				scan      = MODE_EQ;
				tok_start = p;
				return;
			end
			CH_BANG: begin
				scan      = MODE_BANG;
				tok_start = p;
				return;
			end
			CH_SLASH: begin
				scan      = MODE_SLASH;
				tok_start = p;
				return;
			end
			"+": kind = K_PLUS;
			"-": kind = K_MINUS;
			"*": kind = K_STAR;
			"%": kind = K_PCT;
			"(": kind = K_LPAREN;
			")": kind = K_RPAREN;
			"{": kind = K_LBRACE;
			"}": kind = K_RBRACE;
			";": kind = K_SEMI;
			",": kind = K_COMMA;
			".": kind = K_DOT;
			"<": kind = K_LT;
			">": kind = K_GT;
			default: kind = K_UNKNOWN;
		endcase
		add_token(kind, p, 1, kind == K_UNKNOWN);
	endfunction

	// one accepted source beat: advance the scanner, queue the tokens it yields
	function automatic void lex_beat(input logic [7:0] c, input logic eoi);
		int unsigned p;
		p = at_pos;
		fresh.delete();
		if (eoi) begin
			close_token();
			add_token(K_EOF, p, 0, 1'b0);
			clear_scan();
			at_pos = 0;
		end else begin
			case (scan)
				MODE_IDENT: begin
					if (is_letter(c) || is_numeral(c) || c == CH_USCORE) begin
						kw_live = narrow_kw(kw_live, c, tok_len);
						tok_len = bump(tok_len);
					end else begin
						close_token();
						open_token(c, p);
					end
				end
				MODE_INT: begin
					if (is_numeral(c)) begin
						tok_len = bump(tok_len);
					end else begin
						close_token();
						open_token(c, p);
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						add_token(K_STR, tok_start, tok_len, 1'b0);
						clear_scan();
					end else begin
						tok_len = bump(tok_len);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NL) begin
						clear_scan();
					end
				end
				MODE_EQ, MODE_BANG: begin
					if (c == CH_EQ) begin
						add_token((scan == MODE_EQ) ? K_EQEQ : K_NEQ, tok_start, 2, 1'b0);
						clear_scan();
					end else begin
						close_token();
						open_token(c, p);
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						clear_scan();
						scan = MODE_COMMENT;
					end else begin
						close_token();
						open_token(c, p);
					end
				end
				default: open_token(c, p);
			endcase
			at_pos = bump(p);
		end
		if (fresh.size() > 0) begin
			fresh[fresh.size() - 1].last_result = 1'b1;
		end
		foreach (fresh[i]) begin
			due_tokens.push_back(fresh[i]);
		end
	endfunction

	// stimulus builders
	function automatic void queue_beat(input logic [7:0] c, input logic eoi, input logic burst);
		src_beat_t b;
		b.ch    = c;
		b.eoi   = eoi;
		b.burst = burst;
		byte_queue.push_back(b);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			queue_beat(s[i], 1'b0, 1'b0);
		end
	endfunction

	function automatic void add_end();
		queue_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
	endfunction

	function automatic logic [7:0] rand_blank();
		return ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
	endfunction

	function automatic logic [7:0] rand_word_char(input bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26) begin
			return 8'("a" + r);
		end else if (r < 52) begin
			return 8'("A" + r - 26);
		end else if (r == 52) begin
			return CH_USCORE;
		end
		return 8'("0" + r - 53);
	endfunction

	function automatic void add_random_token();
		string kw;
		int    n;
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: add_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
			4: begin
				// near misses: keyword prefix or keyword with a tail
				kw = kw_words[$urandom_range(0, KW_COUNT - 1)];
				if ($urandom_range(0, 1) == 0) begin
					add_text(kw.substr(0, kw.len() - 2));
				end else begin
					add_text(kw);
					queue_beat(rand_word_char(1'b0), 1'b0, 1'b0);
				end
			end
			5, 6: begin
				n = $urandom_range(1, 10);
				queue_beat(rand_word_char(1'b1), 1'b0, 1'b0);
				for (int i = 1; i < n; i++) begin
					queue_beat(rand_word_char(1'b0), 1'b0, 1'b0);
				end
			end
			7: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					queue_beat(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0);
				end
			end
			8: begin
				queue_beat(CH_QUOTE, 1'b0, 1'b0);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					c = 8'($urandom_range(0, 254));
					queue_beat((c >= CH_QUOTE) ? c + 8'd1 : c, 1'b0, 1'b0);
				end
				queue_beat(CH_QUOTE, 1'b0, 1'b0);
			end
			9, 10, 11: queue_beat(punct_chars[$urandom_range(0, punct_chars.len() - 1)],
					1'b0, 1'b0);
			12: add_text("==");
			13: add_text("!=");
			14: begin
				add_text("//");
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++) begin
					c = 8'($urandom_range(0, 254));
					queue_beat((c >= CH_NL) ? c + 8'd1 : c, 1'b0, 1'b0);
				end
				queue_beat(CH_NL, 1'b0, 1'b0);
			end
			15: queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			16: queue_beat(CH_BANG, 1'b0, 1'b0);
			default: queue_beat(rand_blank(), 1'b0, 1'b0);
		endcase
		if ($urandom_range(0, 1) == 0) begin
			queue_beat(rand_blank(), 1'b0, 1'b0);
		end
		if ($urandom_range(0, 24) == 0) begin
			add_end();
		end
	endfunction

	// source driver
	src_beat_t on_wire;
	int        send_gap = 0;
	bit        send_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars.valid        <= 1'b0;
			chars.char_byte    <= '0;
			chars.end_of_input <= 1'b0;
			send_gap = 0;
		end else begin
			if (chars.valid && chars.ready) begin
				lex_beat(on_wire.ch, on_wire.eoi);
				if ($urandom_range(0, 29) == 0) begin
					send_calm = !send_calm;
				end
				send_gap = (send_calm || on_wire.burst) ? 0 : $urandom_range(0, 14);
			end
			if (!chars.valid || chars.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					chars.valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					on_wire = byte_queue.pop_front();
					chars.valid        <= 1'b1;
					chars.char_byte    <= on_wire.ch;
					chars.end_of_input <= on_wire.eoi;
				end else begin
					chars.valid <= 1'b0;
				end
			end
		end
	end

	// token monitor and receiver stalls
	int     stall_left = 0;
	int     hold_left = 0;
	int     beats_seen = 0;
	bit     recv_calm = 1'b0;
	token_t got;
	token_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (tokens.valid && tokens.ready) begin
				got.token_kind   = tokens.token_kind;
				got.token_start  = tokens.token_start;
				got.token_length = tokens.token_length;
				got.unknown_char = tokens.unknown_char;
				got.last_result  = tokens.last_result;
				if (due_tokens.size() == 0) begin
					note_mismatch($sformatf("token beat with nothing expected: kind %0d",
						got.token_kind));
				end else begin
					want = due_tokens.pop_front();
					if (got.token_kind !== want.token_kind)
						note_mismatch($sformatf("beat %0d kind %0d, expected %0d",
							beats_seen, got.token_kind, want.token_kind));
					if (got.token_start !== want.token_start)
						note_mismatch($sformatf("beat %0d start %0d, expected %0d",
							beats_seen, got.token_start, want.token_start));
					if (got.token_length !== want.token_length)
						note_mismatch($sformatf("beat %0d length %0d, expected %0d",
							beats_seen, got.token_length, want.token_length));
					if (got.unknown_char !== want.unknown_char)
						note_mismatch($sformatf("beat %0d unknown_char %b, expected %b",
							beats_seen, got.unknown_char, want.unknown_char));
					if (got.last_result !== want.last_result)
						note_mismatch($sformatf("beat %0d last_result %b, expected %b",
							beats_seen, got.last_result, want.last_result));
				end
				beats_seen++;
				// long hold-offs let the output queue fill and back-pressure the input
				if (beats_seen == 50 || beats_seen == 500) begin
					hold_left = HOLD_CYCLES;
				end
				if ($urandom_range(0, 29) == 0) begin
					recv_calm = !recv_calm;
				end
				stall_left = recv_calm ? 0 : $urandom_range(0, 14);
			end
			if (hold_left > 0) begin
				hold_left--;
				tokens.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				tokens.ready <= 1'b0;
			end else begin
				tokens.ready <= 1'b1;
			end
		end
	end

	initial begin
		chars.valid        = 1'b0;
		chars.char_byte    = '0;
		chars.end_of_input = 1'b0;
		tokens.ready       = 1'b0;
		clear_scan();
		at_pos = 0;

		// directed: == and != , lone slash at end, lone bang, unterminated string,
		// lone equal at end, comment at end, byte extremes
		add_text("if==1!=/");
		add_end();
		queue_beat(8'h09, 1'b0, 1'b0);
		add_text("!x\"q");
		queue_beat(8'hFF, 1'b0, 1'b0);
		add_end();
		add_text("=");
		add_end();
		add_text("//c");
		add_end();
		queue_beat(8'h00, 1'b0, 1'b0);
		queue_beat(8'h80, 1'b0, 1'b0);
		add_end();

		add_text("while x1 ==");
		add_end();

		for (int i = 0; i < RANDOM_BEATS; ) begin
			i -= byte_queue.size();
			add_random_token();
			i += byte_queue.size();
		end
		add_end();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() > 0 || chars.valid) begin
			@(posedge clk);
		end
		for (int i = 0; i < 10000 && due_tokens.size() > 0; i++) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (due_tokens.size() > 0) begin
			note_mismatch($sformatf("%0d expected tokens never arrived", due_tokens.size()));
		end
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
